// File: sv/fbb_pkg.sv
// Package for the free block bitmap allocator.
// Holds the operation codes, the index widths and the payload and word-unit structs.
// Used by fbb_word_unit and free_block_bitmap.
package fbb_pkg;

  localparam int WORD_BITS = 8;
  localparam int BIT_W     = 3;
  localparam int IDX_W     = 13;
  localparam int WIDX_W    = IDX_W - BIT_W;
  localparam int POS_W     = 12;
  localparam int CNT_W     = 13;

  localparam logic [2:0] OP_GET      = 3'd0;
  localparam logic [2:0] OP_SET      = 3'd1;
  localparam logic [2:0] OP_CLEAR    = 3'd2;
  localparam logic [2:0] OP_SEARCH   = 3'd3;
  localparam logic [2:0] OP_FREE_RUN = 3'd4;

  localparam logic [IDX_W-1:0] BLOCK_COUNT_RESET = 13'd4096;

  typedef struct packed {
    logic [2:0]       op;
    logic [POS_W-1:0] position;
    logic [CNT_W-1:0] count;
    logic             match_value;
    logic [IDX_W-1:0] search_limit;
  } in_item_t;

  typedef struct packed {
    logic             bit_value;
    logic             found;
    logic [POS_W-1:0] result_position;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic             want;
    logic [CNT_W-1:0] cnt;
  } word_ctl_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] new_word;
    logic                 bit_value;
    logic                 hit;
    logic [IDX_W-1:0]     hit_pos;
    logic [CNT_W-1:0]     run;
  } word_res_t;

endpackage

// File: sv/free_block_bitmap.sv
// Free block bitmap allocator: one used/free bit per storage block.
// Input items arrive on in_valid/in_stall with an fbb_pkg::in_item_t payload and each gives
// exactly one fbb_pkg::out_item_t result on out_valid/out_stall. The block_count register is
// written through cfg_valid/cfg_ready, which is always ready.
// Operations are get bit, set run, clear run, search for a value in a window, and find the
// first free run of a given length. The map is held as 8-block words in one memory, and a
// sequencer walks the words of the window through one shared word unit.
// Each word of the window passes through ST_READ, a registered memory read, and ST_EXEC, where
// the word unit works on it and the write-back of a run update takes place. The result goes
// from ST_DONE into the output register; items whose window is empty skip the walk and go
// straight to ST_DONE. A search stops at the first hit and a get reads a single word.
// in_stall is high while an item is in work, so one item is handled at a time.
// The result sits in an output register; while the receiver stalls, the next item is still
// accepted and worked on, and its result waits until the output register is free.
// After reset the map is cleared one word per cycle, all NUM_WORDS words (512 at the default
// size) with in_stall high. block_count resets to 4096.
module free_block_bitmap #(
  parameter int unsigned NUM_BLOCKS = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fbb_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fbb_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fbb_pkg::IDX_W-1:0]       cfg_data
);

  localparam int unsigned IDX_MAX    = (1 << fbb_pkg::IDX_W) - 1;
  localparam int unsigned MAP_BLOCKS = (NUM_BLOCKS < IDX_MAX) ? NUM_BLOCKS : IDX_MAX;
  localparam int unsigned NUM_WORDS  = (MAP_BLOCKS + fbb_pkg::WORD_BITS - 1) / fbb_pkg::WORD_BITS;
  localparam int unsigned AW         = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [fbb_pkg::IDX_W-1:0] CAP = fbb_pkg::IDX_W'(MAP_BLOCKS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DONE
  } state_t;

  state_t                            state;
  logic [AW-1:0]                     clr_addr;
  logic [fbb_pkg::IDX_W-1:0]         block_count;
  fbb_pkg::word_ctl_t                ctl;
  logic [fbb_pkg::WIDX_W-1:0]        word;
  logic [fbb_pkg::WIDX_W-1:0]        last_word;
  logic [fbb_pkg::CNT_W-1:0]         run;
  logic                              res_bit;
  logic                              res_found;
  logic [fbb_pkg::POS_W-1:0]         res_pos;
  logic [fbb_pkg::WORD_BITS-1:0]     rdata;
  logic [fbb_pkg::WORD_BITS-1:0]     mem [NUM_WORDS];

  logic [fbb_pkg::IDX_W-1:0]         eff;
  logic [fbb_pkg::IDX_W-1:0]         pos13;
  logic [fbb_pkg::IDX_W:0]           run_end;
  logic [fbb_pkg::IDX_W-1:0]         set_hi;
  logic [fbb_pkg::IDX_W-1:0]         srch_hi;
  logic [fbb_pkg::IDX_W-1:0]         next_lo;
  logic [fbb_pkg::IDX_W-1:0]         next_hi;
  logic [fbb_pkg::IDX_W-1:0]         hi_m1;
  logic                              walk;
  logic                              pre_found;
  logic                              is_update;
  logic                              mem_we;
  logic [AW-1:0]                     mem_waddr;
  logic [fbb_pkg::WORD_BITS-1:0]     mem_wdata;
  fbb_pkg::word_res_t                res;

  fbb_word_unit u_word_unit (
    .ctl      (ctl),
    .word_idx (word),
    .rdata    (rdata),
    .run_in   (run),
    .res      (res)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign eff     = (block_count > CAP) ? CAP : block_count;
  assign pos13   = fbb_pkg::IDX_W'(in_data.position);
  assign run_end = (fbb_pkg::IDX_W + 1)'(in_data.position) + (fbb_pkg::IDX_W + 1)'(in_data.count);
  assign set_hi  = (run_end > {1'b0, eff}) ? eff : run_end[fbb_pkg::IDX_W-1:0];
  assign srch_hi = (in_data.search_limit < eff) ? in_data.search_limit : eff;
  assign hi_m1   = next_hi - 1'b1;

  always_comb begin
    next_lo   = pos13;
    next_hi   = '0;
    walk      = 1'b0;
    pre_found = 1'b0;
    case (in_data.op)
      fbb_pkg::OP_GET: begin
        next_hi = pos13 + 1'b1;
        walk    = (pos13 < eff);
      end
      fbb_pkg::OP_SET, fbb_pkg::OP_CLEAR: begin
        next_hi   = set_hi;
        walk      = (pos13 < set_hi);
        pre_found = 1'b1;
      end
      fbb_pkg::OP_SEARCH: begin
        next_hi = srch_hi;
        walk    = (pos13 < srch_hi);
      end
      fbb_pkg::OP_FREE_RUN: begin
        next_lo   = '0;
        next_hi   = eff;
        walk      = (in_data.count != '0) && (in_data.count <= eff);
        pre_found = (in_data.count == '0);
      end
      default: begin
        next_lo = '0;
      end
    endcase
  end

  assign is_update = (ctl.op == fbb_pkg::OP_SET) || (ctl.op == fbb_pkg::OP_CLEAR);
  assign mem_we    = (state == ST_CLEAR) || ((state == ST_EXEC) && is_update);
  assign mem_waddr = (state == ST_CLEAR) ? clr_addr : word[AW-1:0];
  assign mem_wdata = (state == ST_CLEAR) ? '0 : res.new_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[word[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      block_count <= fbb_pkg::BLOCK_COUNT_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        block_count <= cfg_data;
      end
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(NUM_WORDS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            ctl.op    <= in_data.op;
            ctl.lo    <= next_lo;
            ctl.hi    <= next_hi;
            ctl.want  <= in_data.match_value;
            ctl.cnt   <= in_data.count;
            word      <= next_lo[fbb_pkg::IDX_W-1:fbb_pkg::BIT_W];
            last_word <= hi_m1[fbb_pkg::IDX_W-1:fbb_pkg::BIT_W];
            run       <= '0;
            res_bit   <= 1'b0;
            res_found <= pre_found;
            res_pos   <= '0;
            state     <= walk ? ST_READ : ST_DONE;
          end
        end
        ST_READ: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          run <= res.run;
          if (ctl.op == fbb_pkg::OP_GET) begin
            res_bit   <= res.bit_value;
            res_found <= 1'b1;
            state     <= ST_DONE;
          end else if (!is_update && res.hit) begin
            res_found <= 1'b1;
            res_pos   <= res.hit_pos[fbb_pkg::POS_W-1:0];
            state     <= ST_DONE;
          end else if (word == last_word) begin
            state <= ST_DONE;
          end else begin
            word  <= word + 1'b1;
            state <= ST_READ;
          end
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_data.bit_value       <= res_bit;
            out_data.found           <= res_found;
            out_data.result_position <= res_pos;
            out_valid                <= 1'b1;
            state                    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != ST_IDLE))
    else $error("Accepted transfer did not start the sequencer.");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> (word <= last_word))
    else $error("Word walk passed the end of the window.");

  a_window_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (ctl.lo < ctl.hi))
    else $error("Word walk started on an empty window.");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("Result appeared without a finished operation.");

  a_miss_position_zero: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && !res_found) |-> (res_pos == '0))
    else $error("Position is nonzero on a miss.");

endmodule

// File: sv/fbb_word_unit.sv
// Shared word unit of the free block bitmap allocator.
// Processes one 8-block map word: window mask, run update, value search, free-run count.
// Depends on fbb_pkg.
module fbb_word_unit (
  input  fbb_pkg::word_ctl_t                   ctl,
  input  logic [fbb_pkg::WIDX_W-1:0]           word_idx,
  input  logic [fbb_pkg::WORD_BITS-1:0]        rdata,
  input  logic [fbb_pkg::CNT_W-1:0]            run_in,
  output fbb_pkg::word_res_t                   res
);

  logic [fbb_pkg::IDX_W-1:0]     wnd_idx;
  logic [fbb_pkg::IDX_W-1:0]     run_idx;
  logic [fbb_pkg::WORD_BITS-1:0] inwin;
  logic [fbb_pkg::WORD_BITS-1:0] match;
  logic [fbb_pkg::BIT_W-1:0]     first;
  logic [fbb_pkg::CNT_W-1:0]     run_v;
  logic                          fr_hit;
  logic [fbb_pkg::IDX_W-1:0]     fr_pos;

  always_comb begin
    wnd_idx = '0;
    for (int b = 0; b < fbb_pkg::WORD_BITS; b++) begin
      wnd_idx  = {word_idx, fbb_pkg::BIT_W'(b)};
      inwin[b] = (wnd_idx >= ctl.lo) && (wnd_idx < ctl.hi);
    end
  end

  assign match = inwin & (ctl.want ? rdata : ~rdata);

  always_comb begin
    first = '0;
    for (int b = fbb_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (match[b]) begin
        first = fbb_pkg::BIT_W'(b);
      end
    end
  end

  always_comb begin
    run_v   = run_in;
    fr_hit  = 1'b0;
    fr_pos  = '0;
    run_idx = '0;
    for (int b = 0; b < fbb_pkg::WORD_BITS; b++) begin
      run_idx = {word_idx, fbb_pkg::BIT_W'(b)};
      if (inwin[b] && !fr_hit) begin
        run_v = rdata[b] ? '0 : run_v + 1'b1;
        if (run_v == ctl.cnt) begin
          fr_hit = 1'b1;
          fr_pos = run_idx + fbb_pkg::IDX_W'(1) - ctl.cnt;
        end
      end
    end
  end

  always_comb begin
    res.new_word  = (ctl.op == fbb_pkg::OP_SET) ? (rdata | inwin) : (rdata & ~inwin);
    res.bit_value = |(rdata & inwin);
    res.run       = run_v;
    if (ctl.op == fbb_pkg::OP_SEARCH) begin
      res.hit     = |match;
      res.hit_pos = {word_idx, first};
    end else begin
      res.hit     = fr_hit;
      res.hit_pos = fr_pos;
    end
  end

endmodule
